// ===== rtl/core/mppt_ic_pkg.sv =====
`default_nettype none

package mppt_ic_pkg;

  localparam int DRIVE_BITS = 12;
  localparam int MV_BITS    = 16;
  localparam int UA_BITS    = 22;
  localparam int UW_BITS    = 28;
  localparam int NUM_BITS   = 24;
  localparam int CFG_BITS   = 24;
  localparam int IDX_BITS   = 3;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = NUM_BITS;
  localparam int CNT_BITS  = $clog2(DIV_STEPS);
  // shift-add multiplier: one bit of the slope threshold per cycle
  localparam int MUL_STEPS = MV_BITS;
  localparam int PROD_BITS = 2 * MV_BITS;

  // wide enough for drive + step or drive - 2 * step, plus the alive bit
  localparam int ACC_BITS = MV_BITS + 3;

  localparam logic [MV_BITS-1:0] STEP_SAT = {MV_BITS{1'b1}};

  typedef enum logic [IDX_BITS-1:0] {
    REG_OUTPUT_MIN     = 3'd0,
    REG_OUTPUT_MAX     = 3'd1,
    REG_STEP_NUMERATOR = 3'd2,
    REG_VOLTAGE_TH     = 3'd3,
    REG_CURRENT_TH     = 3'd4,
    REG_SLOPE_TH       = 3'd5,
    REG_ENABLE_V       = 3'd6
  } reg_index_t;

  localparam logic [DRIVE_BITS-1:0] RST_OUTPUT_MIN     = 12'd0;
  localparam logic [DRIVE_BITS-1:0] RST_OUTPUT_MAX     = 12'd4095;
  localparam logic [NUM_BITS-1:0]   RST_STEP_NUMERATOR = 24'd409500;
  localparam logic [MV_BITS-1:0]    RST_VOLTAGE_TH     = 16'd100;
  localparam logic [UA_BITS-1:0]    RST_CURRENT_TH     = 22'd2000;
  localparam logic [MV_BITS-1:0]    RST_SLOPE_TH       = 16'd5;
  localparam logic [MV_BITS-1:0]    RST_ENABLE_V       = 16'd4000;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DIV    = 4'b0010,
    S_DECIDE = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/mppt_incremental_conductance_step.sv =====
`default_nettype none

// channel   signals                                          role
// in        in_valid in_stall solar_mv solar_ua solar_uw    one control tick of samples
//           battery_mv
// out       out_valid out_stall drive_level                  one clamped drive level per tick
// cfg       cfg_we cfg_index cfg_data                        register writes, no read-back
//
// a tick runs from transfer to transfer through the accept, the restoring divider (one
// quotient bit each step, the slope multiply runs alongside it), the decide state and the
// update state
// in_stall is high from accept until the update is done
// rst is synchronous: configuration registers return to their defaults, tracking state to zero
// a stalled result holds; the update of a following tick waits until it is taken

module mppt_incremental_conductance_step (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [mppt_ic_pkg::IDX_BITS-1:0]  cfg_index,
  input  wire logic [mppt_ic_pkg::CFG_BITS-1:0]  cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [mppt_ic_pkg::MV_BITS-1:0]   solar_mv,
  input  wire logic [mppt_ic_pkg::UA_BITS-1:0]   solar_ua,
  input  wire logic [mppt_ic_pkg::UW_BITS-1:0]   solar_uw,
  input  wire logic [mppt_ic_pkg::MV_BITS-1:0]   battery_mv,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mppt_ic_pkg::DRIVE_BITS-1:0]     drive_level
);

  localparam int DB  = mppt_ic_pkg::DRIVE_BITS;
  localparam int MVB = mppt_ic_pkg::MV_BITS;
  localparam int UAB = mppt_ic_pkg::UA_BITS;
  localparam int UWB = mppt_ic_pkg::UW_BITS;
  localparam int NB  = mppt_ic_pkg::NUM_BITS;
  localparam int CB  = mppt_ic_pkg::CNT_BITS;
  localparam int PB  = mppt_ic_pkg::PROD_BITS;
  localparam int AB  = mppt_ic_pkg::ACC_BITS;

  localparam logic [CB-1:0] DIV_LAST  = CB'(mppt_ic_pkg::DIV_STEPS - 1);
  localparam logic [CB-1:0] MUL_COUNT = CB'(mppt_ic_pkg::MUL_STEPS);

  // configuration
  logic [DB-1:0]  output_min;
  logic [DB-1:0]  output_max;
  logic [NB-1:0]  step_numerator;
  logic [MVB-1:0] voltage_th;
  logic [UAB-1:0] current_th;
  logic [MVB-1:0] slope_th;
  logic [MVB-1:0] enable_v;

  // tracking state
  logic [DB-1:0]  drive_accum;
  logic [MVB-1:0] prev_voltage;
  logic [UAB-1:0] prev_current;
  logic [UWB-1:0] prev_power;

  // latched tick
  logic [MVB-1:0] v_in;
  logic [UAB-1:0] i_in;
  logic [UWB-1:0] p_in;
  logic [MVB-1:0] bat;
  logic           dv_neg;
  logic [MVB-1:0] dv_mag;

  mppt_ic_pkg::state_t state;
  logic [CB-1:0]  cnt;

  // divider: numerator bits leave at the top, quotient bits enter at the bottom
  logic [NB-1:0]  num;
  logic [MVB-1:0] rem;
  logic [MVB:0]   rem_shift;
  logic [MVB:0]   rem_sub;
  logic           fits;

  // multiplier: slope threshold times |dv|
  logic [PB-1:0]  mcand;
  logic [MVB-1:0] mplier;
  logic [PB-1:0]  prod;

  // decide results
  logic [MVB-1:0] step;
  logic           go_up;
  logic           go_down;
  logic           alive;
  logic           small_dv;

  logic           in_xfer;
  logic           upd_go;
  logic [MVB:0]   dv_full;

  logic [UAB:0]   di;
  logic [UAB:0]   cth_pos;
  logic [UAB:0]   cth_neg;
  logic [UWB:0]   dp;
  logic [PB+1:0]  dp_ext;
  logic [PB+1:0]  m_pos;
  logic [PB+1:0]  m_neg;
  logic           small_next;
  logic           up_next;
  logic           down_next;
  logic [MVB-1:0] step_next;

  logic [AB-1:0]  delta;
  logic [AB-1:0]  acc;
  logic [DB-1:0]  drive_next;

  assign in_stall    = (state != mppt_ic_pkg::S_IDLE);
  assign in_xfer     = in_valid && !in_stall;
  assign upd_go      = (state == mppt_ic_pkg::S_UPDATE) && (!out_valid || !out_stall);
  assign drive_level = drive_accum;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_min     <= mppt_ic_pkg::RST_OUTPUT_MIN;
      output_max     <= mppt_ic_pkg::RST_OUTPUT_MAX;
      step_numerator <= mppt_ic_pkg::RST_STEP_NUMERATOR;
      voltage_th     <= mppt_ic_pkg::RST_VOLTAGE_TH;
      current_th     <= mppt_ic_pkg::RST_CURRENT_TH;
      slope_th       <= mppt_ic_pkg::RST_SLOPE_TH;
      enable_v       <= mppt_ic_pkg::RST_ENABLE_V;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mppt_ic_pkg::REG_OUTPUT_MIN:     output_min     <= cfg_data[DB-1:0];
        mppt_ic_pkg::REG_OUTPUT_MAX:     output_max     <= cfg_data[DB-1:0];
        mppt_ic_pkg::REG_STEP_NUMERATOR: step_numerator <= cfg_data[NB-1:0];
        mppt_ic_pkg::REG_VOLTAGE_TH:     voltage_th     <= cfg_data[MVB-1:0];
        mppt_ic_pkg::REG_CURRENT_TH:     current_th     <= cfg_data[UAB-1:0];
        mppt_ic_pkg::REG_SLOPE_TH:       slope_th       <= cfg_data[MVB-1:0];
        mppt_ic_pkg::REG_ENABLE_V:       enable_v       <= cfg_data[MVB-1:0];
        default: ;
      endcase
    end
  end

  // voltage change, kept as sign and magnitude
  always_comb begin
    dv_full = {1'b0, solar_mv} - {1'b0, prev_voltage};
  end

  always_comb begin
    rem_shift = {rem, num[NB-1]};
    rem_sub   = rem_shift - {1'b0, bat};
    fits      = (rem_shift >= {1'b0, bat});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mppt_ic_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        mppt_ic_pkg::S_IDLE: begin
          if (in_xfer) begin
            state <= mppt_ic_pkg::S_DIV;
            cnt   <= '0;
          end
        end
        mppt_ic_pkg::S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == DIV_LAST) state <= mppt_ic_pkg::S_DECIDE;
        end
        mppt_ic_pkg::S_DECIDE: state <= mppt_ic_pkg::S_UPDATE;
        mppt_ic_pkg::S_UPDATE: begin
          if (upd_go) state <= mppt_ic_pkg::S_IDLE;
        end
        default: state <= mppt_ic_pkg::S_IDLE;
      endcase
    end
  end

  // datapath: tick latch, divider and multiplier
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      v_in   <= solar_mv;
      i_in   <= solar_ua;
      p_in   <= solar_uw;
      bat    <= battery_mv;
      dv_neg <= dv_full[MVB];
      dv_mag <= dv_full[MVB] ? MVB'(-dv_full) : dv_full[MVB-1:0];
      num    <= step_numerator;
      rem    <= '0;
      mplier <= slope_th;
      mcand  <= PB'(dv_full[MVB] ? MVB'(-dv_full) : dv_full[MVB-1:0]);
      prod   <= '0;
    end else if (state == mppt_ic_pkg::S_DIV) begin
      num <= {num[NB-2:0], fits};
      rem <= fits ? rem_sub[MVB-1:0] : rem_shift[MVB-1:0];
      if (cnt < MUL_COUNT) begin
        if (mplier[0]) prod <= prod + mcand;
        mcand  <= {mcand[PB-2:0], 1'b0};
        mplier <= {1'b0, mplier[MVB-1:1]};
      end
    end
  end

  always_comb begin
    small_next = (dv_mag <= voltage_th);
    di         = {1'b0, i_in} - {1'b0, prev_current};
    cth_pos    = {1'b0, current_th};
    cth_neg    = -cth_pos;
    dp         = {1'b0, p_in} - {1'b0, prev_power};
    dp_ext     = {{(PB + 2 - UWB - 1){dp[UWB]}}, dp};
    m_pos      = {2'b00, prod};
    m_neg      = -m_pos;
    if (small_next) begin
      up_next   = $signed(di) > $signed(cth_pos);
      down_next = $signed(di) < $signed(cth_neg);
    end else if (dv_neg) begin
      // negative dv flips the sense of the slope test
      up_next   = $signed(dp_ext) < $signed(m_neg);
      down_next = $signed(dp_ext) > $signed(m_pos);
    end else begin
      up_next   = $signed(dp_ext) > $signed(m_pos);
      down_next = $signed(dp_ext) < $signed(m_neg);
    end
    step_next = (bat == '0 || num[NB-1:MVB] != '0) ? mppt_ic_pkg::STEP_SAT : num[MVB-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == mppt_ic_pkg::S_DECIDE) begin
      small_dv <= small_next;
      go_up    <= up_next;
      go_down  <= down_next;
      step     <= step_next;
      alive    <= (v_in > enable_v) && (i_in > current_th);
    end
  end

  always_comb begin
    if (go_up) delta = {3'b000, step};
    else if (go_down) delta = -{2'b00, step, 1'b0};
    else delta = '0;
    acc = {{(AB - DB){1'b0}}, drive_accum} + delta
          + (alive ? AB'(1) : {AB{1'b1}});
    if ($signed(acc) > $signed({{(AB - DB){1'b0}}, output_max})) drive_next = output_max;
    else if ($signed(acc) < $signed({{(AB - DB){1'b0}}, output_min})) drive_next = output_min;
    else drive_next = acc[DB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_accum  <= '0;
      prev_voltage <= '0;
      prev_current <= '0;
      prev_power   <= '0;
    end else if (upd_go) begin
      drive_accum <= drive_next;
      if (!small_dv) begin
        prev_voltage <= v_in;
        prev_current <= i_in;
        prev_power   <= p_in;
      end else if (go_up || go_down) begin
        prev_current <= i_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (upd_go) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == mppt_ic_pkg::S_DIV && cnt == DIV_LAST) |=> state == mppt_ic_pkg::S_DECIDE)
    else $error("divider did not hand over to decide");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mppt_ic_pkg::S_DECIDE && bat != '0) |-> rem < bat)
    else $error("divider remainder not below divisor");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == mppt_ic_pkg::S_UPDATE))
    else $error("result raised outside update");

endmodule

`default_nettype wire
